FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the flow classifier.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: rtl/ifc_pkg.sv
// Package of the IPv4 flow classifier: sizes, status codes and key width.
// No dependencies.
`default_nettype none
package ifc_pkg;
    localparam int FLOW_ENTRIES = 256;
    localparam int IDX_W = $clog2(FLOW_ENTRIES);
    localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);
    localparam int KEY_W = 72;
    localparam logic [3:0] IPV4_VERSION = 4'd4;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_NEW      = 3'd1,
        ST_NOT_IPV4 = 3'd2,
        ST_REFUSED  = 3'd3,
        ST_BAD_PORT = 3'd4,
        ST_FULL     = 3'd5
    } t_status;
endpackage
`default_nettype wire

FILE: rtl/ifc_if.sv
// Valid/ready channel interfaces for headers and results.
// Depends on ifc_pkg.
`default_nettype none
interface ifc_hdr_if;
    logic        valid;
    logic        ready;
    logic        input_port;
    logic [3:0]  ip_version;
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic        deny_new;
    modport source (output valid, input_port, ip_version, protocol, src_addr, dst_addr,
                    deny_new, input ready);
    modport sink (input valid, input_port, ip_version, protocol, src_addr, dst_addr,
                  deny_new, output ready);
endinterface

interface ifc_res_if;
    logic                 valid;
    logic                 ready;
    ifc_pkg::t_status     status;
    logic [7:0]           flow_id;
    modport source (output valid, status, flow_id, input ready);
    modport sink (input valid, status, flow_id, output ready);
endinterface
`default_nettype wire

FILE: rtl/ifc_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none
module ifc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

FILE: rtl/ipv4_flow_classifier.sv
// IPv4 flow classifier top level: sequencer around one key RAM.
// Depends on ifc_pkg, ifc_if (interfaces), ifc_ram and assert_macros.svh.
//
// Usage: headers arrive on the sink channel i_hdr; one result per header
// leaves on the source channel o_res. A transfer happens on a rising edge
// with valid and ready high. i_cfg_we/i_cfg_wdata write new_flow_enable.
// A header is taken only when the block is idle. Wrong port or non-IPv4
// headers have their result registered at the edge of the transfer.
// Otherwise the stored keys are scanned one entry per cycle through the
// single RAM port, whose read data is registered. A hit ends the scan at
// the matching entry; a miss gives its result once every stored flow has
// been compared. A new flow is written into the RAM at the same edge that
// registers its result.
// The result waits in an output register until it is transferred; the
// block takes no new header before the cycle after that, so a stalled
// receiver holds the whole block. Reset clears the flow count and the
// enable; the RAM needs no clearing since only entries below the count
// are compared.
`default_nettype none
`include "assert_macros.svh"
module ipv4_flow_classifier (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_we,
    input  wire logic  i_cfg_wdata,
    ifc_hdr_if.sink    i_hdr,
    ifc_res_if.source  o_res
);
    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} t_state;

    t_state                         r_state;
    logic                           r_enable;
    logic [ifc_pkg::CNT_W-1:0]      r_count;
    logic [ifc_pkg::CNT_W-1:0]      r_ptr;
    logic                           r_rd_pend;
    logic [ifc_pkg::IDX_W-1:0]      r_rd_idx;
    logic [ifc_pkg::KEY_W-1:0]      r_key;
    logic                           r_deny;
    logic                           r_valid;
    ifc_pkg::t_status               r_status;
    logic [7:0]                     r_id;

    logic                           ram_we;
    logic [ifc_pkg::IDX_W-1:0]      ram_addr;
    logic [ifc_pkg::KEY_W-1:0]      ram_rdata;
    logic                           hit;

    assign i_hdr.ready   = (r_state == S_IDLE);
    assign o_res.valid   = r_valid;
    assign o_res.status  = r_status;
    assign o_res.flow_id = r_id;

    // Write happens when the scan finished without a hit, admission holds and the table is not full.
    assign hit     = r_rd_pend && (ram_rdata == r_key);
    assign ram_we  = (r_state == S_SCAN) && !hit && !r_rd_pend
                     && (r_ptr == r_count) && r_enable && !r_deny
                     && (r_count != ifc_pkg::CNT_W'(ifc_pkg::FLOW_ENTRIES));
    assign ram_addr = r_ptr[ifc_pkg::IDX_W-1:0];

    ifc_ram #(.WIDTH(ifc_pkg::KEY_W), .DEPTH(ifc_pkg::FLOW_ENTRIES)) u_keys (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(r_key),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_enable  <= 1'b0;
            r_count   <= '0;
            r_ptr     <= '0;
            r_rd_pend <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_enable <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_hdr.valid) begin
                        r_key  <= {i_hdr.protocol, i_hdr.src_addr, i_hdr.dst_addr};
                        r_deny <= i_hdr.deny_new;
                        r_ptr  <= '0;
                        r_rd_pend <= 1'b0;
                        r_id   <= '0;
                        if (i_hdr.input_port != 1'b0) begin
                            r_status <= ifc_pkg::ST_BAD_PORT;
                            r_valid  <= 1'b1;
                            r_state  <= S_DONE;
                        end else if (i_hdr.ip_version != ifc_pkg::IPV4_VERSION) begin
                            r_status <= ifc_pkg::ST_NOT_IPV4;
                            r_valid  <= 1'b1;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (hit) begin
                        r_status  <= ifc_pkg::ST_HIT;
                        r_id      <= 8'(r_rd_idx);
                        r_valid   <= 1'b1;
                        r_rd_pend <= 1'b0;
                        r_state   <= S_DONE;
                    end else if (r_ptr != r_count) begin
                        r_rd_idx  <= r_ptr[ifc_pkg::IDX_W-1:0];
                        r_rd_pend <= 1'b1;
                        r_ptr     <= r_ptr + 1'b1;
                    end else if (r_rd_pend) begin
                        r_rd_pend <= 1'b0;
                    end else begin
                        r_valid <= 1'b1;
                        r_state <= S_DONE;
                        if (!r_enable || r_deny) begin
                            r_status <= ifc_pkg::ST_REFUSED;
                        end else if (r_count ==
                                     ifc_pkg::CNT_W'(ifc_pkg::FLOW_ENTRIES)) begin
                            r_status <= ifc_pkg::ST_FULL;
                        end else begin
                            r_status <= ifc_pkg::ST_NEW;
                            r_id     <= 8'(r_count);
                            r_count  <= r_count + 1'b1;
                        end
                    end
                end
                S_DONE: begin
                    if (o_res.ready) begin
                        r_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMPL(a_count_max, i_clk, i_rst_n, 1'b1,
                 r_count <= ifc_pkg::CNT_W'(ifc_pkg::FLOW_ENTRIES))
    `ASSERT_IMPL(a_valid_done, i_clk, i_rst_n, r_valid, r_state == S_DONE)
    `ASSERT_NEXT(a_write_counts, i_clk, i_rst_n, ram_we, r_count == $past(r_count) + 1'b1)
endmodule
`default_nettype wire

FILE: dv/tb_ipv4_flow_classifier.sv
// Self-checking testbench of ipv4_flow_classifier: directed table, then random traffic.
// Depends on ifc_pkg, ifc_if and the RTL of the classifier.
`default_nettype none
module tb_ipv4_flow_classifier;
    timeunit 1ns;
    timeprecision 1ps;

    // One parsed header as it is offered on the header channel.
    typedef struct packed {
        logic        port;
        logic [3:0]  ver;
        logic [7:0]  proto;
        logic [31:0] src;
        logic [31:0] dst;
        logic        deny;
    } t_hdr;

    typedef struct packed {
        ifc_pkg::t_status status;
        logic [7:0]       id;
    } t_verdict;

    typedef enum logic {ROW_HDR, ROW_CFG} t_row_kind;

    // A directed row is either a header or a write of new_flow_enable.
    // Where known is set, the expected verdict is typed in by hand.
    typedef struct packed {
        t_row_kind kind;
        logic      enable;
        t_hdr      hdr;
        logic      known;
        t_verdict  verdict;
    } t_row;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 300;
    localparam int HOLD_CYCLES    = 600;
    localparam int PHASE_ITEMS    = 180;
    localparam int TAIL_ITEMS     = 180;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    ifc_hdr_if hdr_ch ();
    ifc_res_if res_ch ();

    ipv4_flow_classifier dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_hdr      (hdr_ch),
        .o_res      (res_ch)
    );

    // Shadow state of the flow table, kept in step with the accepted headers.
    logic [71:0] shadow_keys [ifc_pkg::FLOW_ENTRIES];
    int          shadow_count;
    logic        shadow_enable;

    t_verdict    pending_verdicts[$];
    logic [71:0] seen_keys[$];

    int mismatches;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int quiet_cycles;

    t_row directed_rows[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Classifies one accepted header and updates the shadow table. The
    // checks run port first, then version, then lookup, then admission,
    // then capacity.
    function automatic t_verdict classify(t_hdr h);
        t_verdict    v;
        logic [71:0] key;
        key = {h.proto, h.src, h.dst};
        v.id = 8'd0;
        if (h.port != 1'b0) begin
            v.status = ifc_pkg::ST_BAD_PORT;
            return v;
        end
        if (h.ver != ifc_pkg::IPV4_VERSION) begin
            v.status = ifc_pkg::ST_NOT_IPV4;
            return v;
        end
        for (int n = 0; n < shadow_count; n++) begin
            if (shadow_keys[n] == key) begin
                v.status = ifc_pkg::ST_HIT;
                v.id = n[7:0];
                return v;
            end
        end
        if (!shadow_enable || h.deny) begin
            v.status = ifc_pkg::ST_REFUSED;
        end else if (shadow_count >= ifc_pkg::FLOW_ENTRIES) begin
            v.status = ifc_pkg::ST_FULL;
        end else begin
            shadow_keys[shadow_count] = key;
            v.status = ifc_pkg::ST_NEW;
            v.id = shadow_count[7:0];
            shadow_count++;
        end
        return v;
    endfunction

    // Offers one header and returns at the edge where it is transferred.
    // The valid line stays high afterwards, so back-to-back headers never
    // see it lowered and raised within one time step.
    task automatic offer_header(t_hdr h, logic known, t_verdict typed);
        int       gap;
        t_verdict v;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            hdr_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        hdr_ch.valid      <= 1'b1;
        hdr_ch.input_port <= h.port;
        hdr_ch.ip_version <= h.ver;
        hdr_ch.protocol   <= h.proto;
        hdr_ch.src_addr   <= h.src;
        hdr_ch.dst_addr   <= h.dst;
        hdr_ch.deny_new   <= h.deny;
        do @(posedge i_clk); while (!(hdr_ch.valid && hdr_ch.ready));
        v = classify(h);
        pending_verdicts.push_back(known ? typed : v);
        if (h.port == 1'b0 && h.ver == ifc_pkg::IPV4_VERSION)
            seen_keys.push_back({h.proto, h.src, h.dst});
    endtask

    // Stops offering headers and waits until every verdict has come back,
    // plus a few cycles so the block is surely idle.
    task automatic drain();
        hdr_ch.valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_enable(logic value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_enable = value;
    endtask

    // Mostly well-formed IPv4 headers; about (100 - fresh_pct) percent reuse a key
    // seen before so that hits are common, the rest are fresh random keys.
    function automatic t_hdr random_header(int fresh_pct);
        t_hdr        h;
        logic [71:0] key;
        h.port = ($urandom_range(99) < 8);
        h.ver  = ($urandom_range(99) < 8) ? 4'($urandom_range(15)) : ifc_pkg::IPV4_VERSION;
        h.deny = ($urandom_range(99) < 15);
        if (seen_keys.size() != 0 && $urandom_range(99) >= fresh_pct) begin
            key = seen_keys[$urandom_range(seen_keys.size() - 1)];
        end else begin
            key = {8'($urandom), 32'($urandom), 32'($urandom)};
        end
        {h.proto, h.src, h.dst} = key;
        return h;
    endfunction

    function automatic t_row hdr_row(logic port, logic [3:0] ver, logic [7:0] proto,
                                     logic [31:0] src, logic [31:0] dst, logic deny,
                                     ifc_pkg::t_status st, logic [7:0] id);
        t_row r;
        r.kind = ROW_HDR;
        r.enable = 1'b0;
        r.hdr = '{port, ver, proto, src, dst, deny};
        r.known = 1'b1;
        r.verdict = '{st, id};
        return r;
    endfunction

    function automatic t_row cfg_row(logic value);
        t_row r;
        r = '0;
        r.kind = ROW_CFG;
        r.enable = value;
        return r;
    endfunction

    // The receiver decides ready at every edge and checks each transfer
    // against the oldest pending verdict. A hold-off from the main process
    // keeps ready low for a counted stretch.
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                if (pending_verdicts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: status %0d id %0d",
                                 res_ch.status, res_ch.flow_id);
                end else begin
                    want = pending_verdicts.pop_front();
                    if (res_ch.status !== want.status || res_ch.flow_id !== want.id) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected status %0d id %0d, got %0d %0d",
                                     want.status, want.id, res_ch.status, res_ch.flow_id);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog on cycles without any transfer on either channel.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((hdr_ch.valid && hdr_ch.ready) || (res_ch.valid && res_ch.ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                    $display("SCOREBOARD MISMATCH");
                    $finish;
                end
            end
        end
    end

    initial begin
        t_hdr h;
        t_row r;
        int   fills;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = 1'b0;
        hdr_ch.valid      = 1'b0;
        hdr_ch.input_port = 1'b0;
        hdr_ch.ip_version = 4'd0;
        hdr_ch.protocol   = 8'd0;
        hdr_ch.src_addr   = 32'd0;
        hdr_ch.dst_addr   = 32'd0;
        hdr_ch.deny_new   = 1'b0;
        res_ch.ready      = 1'b0;
        mismatches        = 0;
        quiet_cycles      = 0;
        hold_left         = 0;
        send_idle_pct     = 0;
        recv_idle_pct     = 0;
        shadow_count      = 0;
        shadow_enable     = 1'b0;

        // Directed rows. Admission is off after reset, so the first misses
        // are refused; a wrong port wins over a wrong version.
        directed_rows = '{
            hdr_row(1'b1, 4'd4, 8'h06, 32'h0A000001, 32'h0A000002, 1'b0,
                    ifc_pkg::ST_BAD_PORT, 8'd0),
            hdr_row(1'b0, 4'd0, 8'h06, 32'h0A000001, 32'h0A000002, 1'b0,
                    ifc_pkg::ST_NOT_IPV4, 8'd0),
            hdr_row(1'b0, 4'd15, 8'h11, 32'hFFFFFFFF, 32'h0, 1'b1,
                    ifc_pkg::ST_NOT_IPV4, 8'd0),
            hdr_row(1'b1, 4'd6, 8'h11, 32'h1, 32'h2, 1'b0,
                    ifc_pkg::ST_BAD_PORT, 8'd0),
            hdr_row(1'b0, 4'd4, 8'h00, 32'h0, 32'h0, 1'b0,
                    ifc_pkg::ST_REFUSED, 8'd0),
            cfg_row(1'b1),
            hdr_row(1'b0, 4'd4, 8'h00, 32'h0, 32'h0, 1'b0,
                    ifc_pkg::ST_NEW, 8'd0),
            hdr_row(1'b0, 4'd4, 8'h00, 32'h0, 32'h0, 1'b0,
                    ifc_pkg::ST_HIT, 8'd0),
            hdr_row(1'b0, 4'd4, 8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0,
                    ifc_pkg::ST_NEW, 8'd1),
            // A hit is reported even when the listener would deny a new flow.
            hdr_row(1'b0, 4'd4, 8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1,
                    ifc_pkg::ST_HIT, 8'd1),
            hdr_row(1'b0, 4'd4, 8'h06, 32'hC0A80001, 32'hC0A80002, 1'b1,
                    ifc_pkg::ST_REFUSED, 8'd0),
            // Keys that differ from a stored one in a single field are new.
            hdr_row(1'b0, 4'd4, 8'hFF, 32'h0, 32'hFFFFFFFF, 1'b0,
                    ifc_pkg::ST_NEW, 8'd2),
            hdr_row(1'b0, 4'd4, 8'h00, 32'hFFFFFFFF, 32'h0, 1'b0,
                    ifc_pkg::ST_NEW, 8'd3),
            hdr_row(1'b0, 4'd4, 8'h00, 32'h0, 32'hFFFFFFFF, 1'b0,
                    ifc_pkg::ST_NEW, 8'd4),
            hdr_row(1'b1, 4'd4, 8'h00, 32'h0, 32'h0, 1'b0,
                    ifc_pkg::ST_BAD_PORT, 8'd0),
            hdr_row(1'b0, 4'd5, 8'h00, 32'h0, 32'h0, 1'b0,
                    ifc_pkg::ST_NOT_IPV4, 8'd0),
            cfg_row(1'b0),
            hdr_row(1'b0, 4'd4, 8'h00, 32'hFFFFFFFF, 32'h0, 1'b0,
                    ifc_pkg::ST_HIT, 8'd3),
            hdr_row(1'b0, 4'd4, 8'h2F, 32'h12345678, 32'h9ABCDEF0, 1'b0,
                    ifc_pkg::ST_REFUSED, 8'd0)
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            r = directed_rows[k];
            if (r.kind == ROW_CFG) write_enable(r.enable);
            else offer_header(r.hdr, r.known, r.verdict);
        end

        // Random phases: no idling, idle sender, stalling receiver, both.
        write_enable(1'b1);
        repeat (PHASE_ITEMS) offer_header(random_header(60), 1'b0, '0);

        write_enable(1'b0);
        send_idle_pct = 50;
        repeat (PHASE_ITEMS) offer_header(random_header(50), 1'b0, '0);

        write_enable(1'b1);
        send_idle_pct = 0;
        recv_idle_pct = 50;
        // Long receiver hold-off while headers keep coming, so the output
        // register fills and the header channel stalls.
        hold_left = HOLD_CYCLES;
        repeat (PHASE_ITEMS) offer_header(random_header(60), 1'b0, '0);

        // Sender pause until every verdict is back.
        drain();
        send_idle_pct = 12;
        recv_idle_pct = 12;
        repeat (PHASE_ITEMS) offer_header(random_header(60), 1'b0, '0);

        // Fill the table with fresh flows, then keep going so that misses
        // meet a full table and hits reach the top ids.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fills = 0;
        while (shadow_count < ifc_pkg::FLOW_ENTRIES && fills < 400) begin
            h = random_header(100);
            h.port = 1'b0;
            h.ver = ifc_pkg::IPV4_VERSION;
            h.deny = 1'b0;
            offer_header(h, 1'b0, '0);
            fills++;
        end
        recv_idle_pct = 30;
        repeat (TAIL_ITEMS) offer_header(random_header(50), 1'b0, '0);

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_verdicts.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
`default_nettype wire
